>>> rtl/led_matrix_framebuffer_unit_macros.svh
// assertion macros for the led matrix framebuffer unit
// depends on a clock named clk and an active-low reset named rst_n in the using scope
// LMFB_ASSERT_NOW checks an implication in the same cycle, LMFB_ASSERT_NEXT in the next cycle
`ifndef LED_MATRIX_FRAMEBUFFER_UNIT_MACROS_SVH
`define LED_MATRIX_FRAMEBUFFER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LMFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmfb assertion failed");
`define LMFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmfb assertion failed");
`else
`define LMFB_ASSERT_NOW(label, ante, cons)
`define LMFB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/lmfb_pkg.sv
// shared types and constants of the led matrix framebuffer unit
// no dependencies; used by the row memory and the top level
package lmfb_pkg;

  // chain geometry
  localparam int MAX_DEVICES_DEF = 8;
  localparam int DEVICE_SIZE     = 8;

  // register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DEVICES = 1'b1;
  localparam logic [3:0] NUM_DEVICES_RST = 4'd4;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DIGIT  = 1'b1;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_FLUSH_ROW = 2'd2,
    CMD_FLUSH_ALL = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] row;
    logic [7:0] col;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [3:0] device_addr;
    logic [3:0] digit_addr;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

>>> rtl/lmfb_row_mem.sv
// row word memory with one registered read port and one write port
// entries read as zero until first written after reset; uses lmfb_pkg widths
module lmfb_row_mem #(
  parameter int DEPTH = lmfb_pkg::MAX_DEVICES_DEF * lmfb_pkg::DEVICE_SIZE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [7:0]       rd_word_r;
  logic             rd_written_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word_r <= mem[rd_addr];
  end

  // per-entry written flags stand in for the reset clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      rd_written_r <= written_r[rd_addr];
    end
  end

  assign rd_data = rd_written_r ? rd_word_r : 8'h00;

endmodule

>>> rtl/led_matrix_framebuffer_unit.sv
// Framebuffer for a chain of 8x8 LED matrix drivers.
// Requests come in on in_req and are taken when start is high and busy is low.
// Set and clear requests change one pixel with a read-modify-write of the row
// memory; an out-of-range pixel gives a status with ok low and changes nothing.
// Flush requests stream (device, digit, data) writes row-major, devices in
// order, one per cycle, with last high on the final one.
// Results appear on out_res for one cycle with out_strobe high; the receiver
// cannot stall them and must take every strobed result.
// Sequence: a set or clear reads the memory word, then writes it back, and
// its status shows in the cycle after the write. A flush issues one memory
// read per cycle; each word passes through the registered memory read and
// then the result register. Bad flushes and out-of-range pixels give their
// status the cycle after the request, with no busy time.
// The registered read of the row memory sets this order.
// Configuration writes on cfg_we / cfg_index / cfg_data take effect at once
// and are meant only while the block is idle.
// After reset all row words read as zero, rotated is 0 and 4 devices are used.
// depends on lmfb_pkg, lmfb_row_mem and led_matrix_framebuffer_unit_macros.svh
`include "led_matrix_framebuffer_unit_macros.svh"

module led_matrix_framebuffer_unit #(
  parameter int MAX_DEVICES = lmfb_pkg::MAX_DEVICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lmfb_pkg::req_t                  in_req,
  output logic                            out_strobe,
  output lmfb_pkg::res_t                  out_res,
  input  logic                            cfg_we,
  input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_DEVICES * lmfb_pkg::DEVICE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam logic [3:0] MAX_DEV_4 = 4'(MAX_DEVICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_FLUSH
  } state_t;

  state_t         state_r;
  logic           rotated_r;
  logic [3:0]     num_devices_r;

  logic [AW-1:0]  word_addr_r;
  logic [2:0]     bit_r;
  logic           set_r;

  logic [3:0]     dev_cnt_r;
  logic [2:0]     row_cnt_r;
  logic [2:0]     last_row_r;

  logic           pend_valid_r;
  logic [3:0]     pend_dev_r;
  logic [2:0]     pend_row_r;
  logic           pend_last_r;

  logic           out_strobe_r;
  lmfb_pkg::res_t out_res_r;

  logic [3:0]     n_act;
  logic           accept;
  logic           pix_in_range;
  logic [2:0]     col_in_dev;
  logic [2:0]     pix_word;
  logic [2:0]     pix_bit;
  logic [AW-1:0]  pix_addr;
  logic [AW-1:0]  flush_addr;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;
  logic           wr_en;
  logic [7:0]     wr_data;
  logic [7:0]     bit_mask;
  logic           flush_fin;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotated_r     <= 1'b0;
      num_devices_r <= lmfb_pkg::NUM_DEVICES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmfb_pkg::REG_ROTATED:     rotated_r     <= cfg_data[0];
        lmfb_pkg::REG_NUM_DEVICES: num_devices_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // devices in use, capped at the chain size
  assign n_act = (num_devices_r > MAX_DEV_4) ? MAX_DEV_4 : num_devices_r;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE) || pend_valid_r;

  // pixel mapping into a device word and bit
  assign col_in_dev   = in_req.col[2:0];
  assign pix_in_range = (in_req.row < 8'(lmfb_pkg::DEVICE_SIZE)) &&
                        ({1'b0, in_req.col[7:3]} < {2'b00, n_act});
  assign pix_word     = rotated_r ? col_in_dev :
                        3'(lmfb_pkg::DEVICE_SIZE - 1) - in_req.row[2:0];
  assign pix_bit      = rotated_r ? in_req.row[2:0] : col_in_dev;
  assign pix_addr     = AW'({in_req.col[3 +: DEV_W], pix_word});

  // flush sequencing address and end of sequence
  assign flush_addr = AW'({dev_cnt_r[DEV_W-1:0], row_cnt_r});
  assign flush_fin  = (row_cnt_r == last_row_r) && (dev_cnt_r == n_act - 4'd1);

  assign rd_addr = (state_r == ST_FLUSH) ? flush_addr : pix_addr;

  // read-modify-write of the addressed word
  assign bit_mask = 8'h01 << bit_r;
  assign wr_en    = (state_r == ST_RMW);
  assign wr_data  = set_r ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

  lmfb_row_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_addr_r),
    .wr_data (wr_data)
  );

  // pixel request fields held for the write back
  always_ff @(posedge clk) begin
    if (accept) begin
      word_addr_r <= pix_addr;
      bit_r       <= pix_bit;
      set_r       <= (in_req.cmd == lmfb_pkg::CMD_SET);
    end
  end

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
      dev_cnt_r    <= '0;
      row_cnt_r    <= '0;
      last_row_r   <= '0;
      pend_dev_r   <= '0;
      pend_row_r   <= '0;
      pend_last_r  <= 1'b0;
      out_res_r    <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      pend_valid_r <= 1'b0;

      // word read during the flush comes back in the following cycle
      if (pend_valid_r) begin
        out_strobe_r          <= 1'b1;
        out_res_r.kind        <= lmfb_pkg::KIND_DIGIT;
        out_res_r.ok          <= 1'b1;
        out_res_r.device_addr <= pend_dev_r + 4'd1;
        out_res_r.digit_addr  <= {1'b0, pend_row_r} + 4'd1;
        out_res_r.data        <= rd_data;
        out_res_r.last        <= pend_last_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_req.cmd)
              lmfb_pkg::CMD_SET, lmfb_pkg::CMD_CLEAR: begin
                if (pix_in_range) begin
                  state_r <= ST_RMW;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_res_r    <= '{kind: lmfb_pkg::KIND_STATUS, ok: 1'b0,
                                    device_addr: 4'd0, digit_addr: 4'd0,
                                    data: 8'h00, last: 1'b1};
                end
              end
              lmfb_pkg::CMD_FLUSH_ROW: begin
                if (in_req.row >= 8'(lmfb_pkg::DEVICE_SIZE) || n_act == 4'd0) begin
                  out_strobe_r <= 1'b1;
                  out_res_r    <= '{kind: lmfb_pkg::KIND_STATUS, ok: 1'b0,
                                    device_addr: 4'd0, digit_addr: 4'd0,
                                    data: 8'h00, last: 1'b1};
                end else begin
                  state_r    <= ST_FLUSH;
                  dev_cnt_r  <= '0;
                  row_cnt_r  <= in_req.row[2:0];
                  last_row_r <= in_req.row[2:0];
                end
              end
              lmfb_pkg::CMD_FLUSH_ALL: begin
                if (n_act == 4'd0) begin
                  out_strobe_r <= 1'b1;
                  out_res_r    <= '{kind: lmfb_pkg::KIND_STATUS, ok: 1'b0,
                                    device_addr: 4'd0, digit_addr: 4'd0,
                                    data: 8'h00, last: 1'b1};
                end else begin
                  state_r    <= ST_FLUSH;
                  dev_cnt_r  <= '0;
                  row_cnt_r  <= 3'd0;
                  last_row_r <= 3'(lmfb_pkg::DEVICE_SIZE - 1);
                end
              end
              default: ;
            endcase
          end
        end
        ST_RMW: begin
          state_r      <= ST_IDLE;
          out_strobe_r <= 1'b1;
          out_res_r    <= '{kind: lmfb_pkg::KIND_STATUS, ok: 1'b1,
                            device_addr: 4'd0, digit_addr: 4'd0,
                            data: 8'h00, last: 1'b1};
        end
        ST_FLUSH: begin
          // issue one read per cycle, devices inner, rows outer
          pend_valid_r <= 1'b1;
          pend_dev_r   <= dev_cnt_r;
          pend_row_r   <= row_cnt_r;
          pend_last_r  <= flush_fin;
          if (flush_fin) begin
            state_r <= ST_IDLE;
          end else if (dev_cnt_r == n_act - 4'd1) begin
            dev_cnt_r <= '0;
            row_cnt_r <= row_cnt_r + 3'd1;
          end else begin
            dev_cnt_r <= dev_cnt_r + 4'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // checks
  `LMFB_ASSERT_NOW(a_status_is_last, out_strobe_r && (out_res_r.kind == lmfb_pkg::KIND_STATUS), out_res_r.last && (out_res_r.device_addr == 4'd0))
  `LMFB_ASSERT_NOW(a_no_write_in_flush, state_r == ST_FLUSH, !wr_en)
  `LMFB_ASSERT_NEXT(a_pending_word_shown, pend_valid_r, out_strobe_r && (out_res_r.kind == lmfb_pkg::KIND_DIGIT))
  `LMFB_ASSERT_NEXT(a_write_gives_status, state_r == ST_RMW, out_strobe_r && out_res_r.ok && !busy)

endmodule
